// ===== src/sut_pkg.sv =====
`timescale 1ns / 1ps
// Package for the unsorted symbol table: sizes, operation codes and word types.
// Used by unsorted_symbol_table_core; depends on nothing.
package sut_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  typedef struct packed {
    logic [1:0]            action;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] value_out;
    logic [COUNT_BITS-1:0] entry_count;
    logic                  full_drop;
  } rsp_word_t;

endpackage

// ===== src/unsorted_symbol_table_core.sv =====
`timescale 1ns / 1ps
// Top level of the unsorted symbol table: sequencer, entry count and result register.
// Depends on sut_pkg and sut_ram.
//
//   Channel   Signals                      Direction  Carries
//   command   cmd_valid, cmd_stall, cmd    in         action, key, value
//   response  rsp_valid, rsp_stall, rsp    out        found, value_out, entry_count, full_drop
//
// An insert or an unused action code goes through the result state to the response register.
// A search or delete reads one stored entry at a time through the RAM port, newest first,
// in the scan read and scan check states; a delete hit then moves each newer entry down one
// place through the shift read and shift write states.
// Reset clears the sequencer, the entry count and the response valid flag; the RAM contents
// are not cleared since only entries below the count are ever read. A new command word is
// accepted while a finished response still waits on rsp_stall.
module unsorted_symbol_table_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  sut_pkg::cmd_word_t cmd,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output sut_pkg::rsp_word_t rsp
);

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SCAN_RD  = 6'b000010,
    ST_SCAN_CHK = 6'b000100,
    ST_SHIFT_RD = 6'b001000,
    ST_SHIFT_WR = 6'b010000,
    ST_RESULT   = 6'b100000
  } state_t;

  state_t                             state;
  logic [sut_pkg::COUNT_BITS-1:0]     count;
  logic [sut_pkg::ADDR_BITS-1:0]      idx;
  logic [1:0]                         op;
  logic [sut_pkg::KEY_BITS-1:0]       key;
  sut_pkg::rsp_word_t                 res;

  logic                               ram_we;
  logic [sut_pkg::ADDR_BITS-1:0]      ram_waddr;
  logic [sut_pkg::ENTRY_BITS-1:0]     ram_wdata;
  logic [sut_pkg::ADDR_BITS-1:0]      ram_raddr;
  logic [sut_pkg::ENTRY_BITS-1:0]     ram_rdata;

  logic                               cmd_take;
  logic                               is_full;
  logic                               key_match;
  logic [sut_pkg::COUNT_BITS-1:0]     idx_wide;
  logic [sut_pkg::COUNT_BITS-1:0]     count_dec;
  logic [sut_pkg::ADDR_BITS-1:0]      idx_inc;

  assign cmd_stall = (state != ST_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;

  localparam logic [sut_pkg::COUNT_BITS-1:0] FULL_COUNT =
    sut_pkg::COUNT_BITS'(sut_pkg::CAPACITY);
  localparam logic [sut_pkg::COUNT_BITS-1:0] TWO = sut_pkg::COUNT_BITS'(2);

  assign is_full   = (count == FULL_COUNT);
  assign idx_wide  = {1'b0, idx};
  assign count_dec = count - 1'b1;
  assign idx_inc   = idx + 1'b1;

  // The one shared comparator: stored key of the entry just read against the command key.
  assign key_match = (ram_rdata[sut_pkg::ENTRY_BITS-1:sut_pkg::VALUE_BITS] == key);

  // The write port serves inserts in the accept cycle and entry moves during a delete.
  always_comb begin
    if (state == ST_SHIFT_WR) begin
      ram_we    = 1'b1;
      ram_waddr = idx;
      ram_wdata = ram_rdata;
    end else begin
      ram_we    = cmd_take && (cmd.action == sut_pkg::ACT_INSERT) && !is_full;
      ram_waddr = count[sut_pkg::ADDR_BITS-1:0];
      ram_wdata = {cmd.key, cmd.value};
    end
  end

  // While moving entries down, read the next newer entry; otherwise read the scan position.
  assign ram_raddr = (state == ST_SHIFT_RD) ? idx_inc : idx;

  sut_ram #(
    .WIDTH (sut_pkg::ENTRY_BITS),
    .DEPTH (sut_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // The response word leaves when it is not stalled; in the result state a new one
      // takes its place in the same cycle.
      if (rsp_valid && !rsp_stall && state != ST_RESULT) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            op            <= cmd.action;
            key           <= cmd.key;
            res.found     <= 1'b0;
            res.value_out <= '0;
            if (cmd.action == sut_pkg::ACT_INSERT) begin
              state <= ST_RESULT;
              if (is_full) begin
                res.full_drop   <= 1'b1;
                res.entry_count <= count;
              end else begin
                res.full_drop   <= 1'b0;
                count           <= count + 1'b1;
                res.entry_count <= count + 1'b1;
              end
            end else begin
              res.full_drop   <= 1'b0;
              res.entry_count <= count;
              if ((cmd.action == sut_pkg::ACT_SEARCH ||
                   cmd.action == sut_pkg::ACT_DELETE) && count != '0) begin
                idx   <= count_dec[sut_pkg::ADDR_BITS-1:0];
                state <= ST_SCAN_RD;
              end else begin
                state <= ST_RESULT;
              end
            end
          end
        end

        ST_SCAN_RD: begin
          state <= ST_SCAN_CHK;
        end

        ST_SCAN_CHK: begin
          if (key_match) begin
            res.found <= 1'b1;
            if (op == sut_pkg::ACT_SEARCH) begin
              res.value_out <= ram_rdata[sut_pkg::VALUE_BITS-1:0];
              state         <= ST_RESULT;
            end else if (idx_wide + TWO <= count) begin
              // Newer entries sit above the hit and have to move down.
              state <= ST_SHIFT_RD;
            end else begin
              count           <= count_dec;
              res.entry_count <= count_dec;
              state           <= ST_RESULT;
            end
          end else if (idx == '0) begin
            state <= ST_RESULT;
          end else begin
            idx   <= idx - 1'b1;
            state <= ST_SCAN_RD;
          end
        end

        ST_SHIFT_RD: begin
          state <= ST_SHIFT_WR;
        end

        ST_SHIFT_WR: begin
          idx <= idx_inc;
          if (idx_wide + TWO < count) begin
            state <= ST_SHIFT_RD;
          end else begin
            count           <= count_dec;
            res.entry_count <= count_dec;
            state           <= ST_RESULT;
          end
        end

        ST_RESULT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/sut_ram.sv =====
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port with registered data.
// Depends on nothing.
module sut_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
